// ===== rtl/core/cfmt_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT byte step for the framed message transmitter.
// No dependencies; every other file in rtl/core imports this package.
package cfmt_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Sync bytes 'Z', 'e', 'b', 'u' that open every frame.
    localparam int          SYNC_LEN = 4;
    localparam logic [7:0]  SYNC_BYTES [SYNC_LEN] = '{8'h5A, 8'h65, 8'h62, 8'h75};

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Step counter in the back covers the five header bytes of a start.
    localparam int START_LEN = SYNC_LEN + 1;
    localparam int STEP_W    = $clog2(START_LEN);

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_END
    } cmd_kind_t;

    // The payload carries the type or data byte in its low half, or the whole CRC for an end.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] payload;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t entry;
    } q_wr_t;

    typedef struct packed {
        logic avail;
        cmd_t entry;
    } q_rd_t;

    // One byte of CRC-16/CCITT, polynomial 0x1021, most significant bit first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = crc[15:8] ^ b;
        t = t ^ {4'b0000, t[7:4]};
        return {crc[7:0], 8'h00} ^ {t[3:0], 12'h000} ^ {3'b000, t, 5'b00000} ^ {8'h00, t};
    endfunction

    // CRC after the four sync bytes; only the type byte still has to be folded in.
    localparam logic [15:0] CRC_SYNC =
        crc_fold(crc_fold(crc_fold(crc_fold(CRC_INIT, SYNC_BYTES[0]), SYNC_BYTES[1]),
                          SYNC_BYTES[2]), SYNC_BYTES[3]);

endpackage

// ===== rtl/core/crc_framed_message_transmitter.sv =====
// Top level of the framed message transmitter with a CRC-16/CCITT trailer.
// Instantiates cfmt_front, cfmt_queue and cfmt_back; depends on cfmt_pkg.
//
// The block turns a stream of action items into the bytes of outgoing serial frames.
// Input channel: an item (action, msg_type, data_byte) transfers at a rising edge
// with push high and full low. A start item yields the four sync bytes and the
// message type, a payload item inside a frame yields its byte, and an end item
// inside a frame yields the CRC, low byte first, with frame_done on the high byte.
// Payload and end items outside a frame, and the unused action code, yield nothing.
// Result channel: while empty is low the oldest byte sits on out_byte, run_last and
// frame_done, and it transfers at a rising edge with pop high.
// With the queue and the back idle, an item is first written into the queue, and its
// first byte then goes to the back's output register, which drives the result ports.
// Throughput: one result byte per cycle while pop is high, set by the single output
// register of the back; a payload item is thus taken every cycle, a start item holds
// the back for five bytes, an end item for two. The front's CRC step is XOR logic.
// A four-entry command queue between front and back absorbs bursts; full rises
// only when it fills, so a stalled receiver backs up into the queue and then into
// the sender, and no byte is lost. Reset clears the queue and the output register,
// closes any open frame and reloads the CRC with all ones.
module crc_framed_message_transmitter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] action,
    input  logic [7:0] msg_type,
    input  logic [7:0] data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_done
);
    import cfmt_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_pop;

    // The front classifies each item and keeps the frame state and running CRC.
    cfmt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .msg_type  (msg_type),
        .data_byte (data_byte),
        .wr        (q_wr)
    );

    // Commands wait here until the back is ready to expand them.
    cfmt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .rd_pop (q_pop),
        .rd     (q_rd),
        .full   (full)
    );

    // The back sequences the bytes of each command into the output register.
    cfmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (q_rd),
        .rd_pop     (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

endmodule

// ===== rtl/core/cfmt_front.sv =====
// Front of the framed message transmitter: accepts action items, tracks the open frame
// and the running CRC, and writes one command per emitting item. Depends on cfmt_pkg.
module cfmt_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           full,
    input  logic [1:0]     action,
    input  logic [7:0]     msg_type,
    input  logic [7:0]     data_byte,
    output cfmt_pkg::q_wr_t wr
);
    import cfmt_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic        accept;

    assign accept = push && !full;

    always_comb
    begin
        crc_next          = crc_reg;
        in_frame_next     = in_frame_reg;
        wr.valid          = 1'b0;
        wr.entry.kind     = CMD_DATA;
        wr.entry.payload  = {8'h00, data_byte};
        case (action)
            ACT_START:
            begin
                wr.entry.kind    = CMD_START;
                wr.entry.payload = {8'h00, msg_type};
                wr.valid         = accept;
                if (accept)
                begin
                    crc_next      = crc_fold(CRC_SYNC, msg_type);
                    in_frame_next = 1'b1;
                end
            end
            ACT_DATA:
            begin
                wr.valid = accept && in_frame_reg;
                if (accept && in_frame_reg)
                begin
                    crc_next = crc_fold(crc_reg, data_byte);
                end
            end
            ACT_END:
            begin
                wr.entry.kind    = CMD_END;
                wr.entry.payload = crc_reg;
                wr.valid         = accept && in_frame_reg;
                if (accept && in_frame_reg)
                begin
                    in_frame_next = 1'b0;
                end
            end
            default:
            begin
                wr.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= CRC_INIT;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// ===== rtl/core/cfmt_queue.sv =====
// Short command queue that decouples the front from the back of the transmitter.
// Depends on cfmt_pkg for the command type and the depth.
module cfmt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  cfmt_pkg::q_wr_t wr,
    input  logic            rd_pop,
    output cfmt_pkg::q_rd_t rd,
    output logic            full
);
    import cfmt_pkg::*;

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd.avail = (count_reg != '0);
    assign rd.entry = mem[head_reg];
    assign do_push  = wr.valid && !full;
    assign do_pop   = rd_pop && rd.avail;

    always_comb
    begin
        head_next  = do_pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = do_push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= wr.entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("command queue count beyond its depth");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid |-> !full)
        else $error("command written while the queue is full");

    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pop |-> rd.avail)
        else $error("command taken from an empty queue");
`endif

endmodule

// ===== rtl/core/cfmt_back.sv =====
// Back of the transmitter: expands each command into its output bytes, one a cycle
// as pop allows, into an output register that the receiver drains. Needs cfmt_pkg.
module cfmt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cfmt_pkg::q_rd_t rd,
    output logic            rd_pop,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            frame_done
);
    import cfmt_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_done_reg;
    logic              out_done_next;

    cmd_t              cur;
    logic              cur_ok;
    logic [STEP_W-1:0] cur_step;
    logic              fire;
    logic [7:0]        gen_byte;
    logic              gen_last;
    logic              gen_done;

    always_comb
    begin
        cur      = busy_reg ? cmd_reg : rd.entry;
        cur_ok   = busy_reg || rd.avail;
        cur_step = busy_reg ? step_reg : '0;
        fire     = cur_ok && (!out_valid_reg || pop);

        gen_byte = cur.payload[7:0];
        gen_last = 1'b1;
        gen_done = 1'b0;
        case (cur.kind)
            CMD_START:
            begin
                if (cur_step < STEP_W'(SYNC_LEN))
                begin
                    gen_byte = SYNC_BYTES[cur_step[PTR_W-1:0]];
                    gen_last = 1'b0;
                end
            end
            CMD_DATA:
            begin
                gen_last = 1'b1;
            end
            CMD_END:
            begin
                if (cur_step == '0)
                begin
                    gen_last = 1'b0;
                end
                else
                begin
                    gen_byte = cur.payload[15:8];
                    gen_done = 1'b1;
                end
            end
            default:
            begin
                gen_last = 1'b1;
            end
        endcase

        rd_pop         = fire && !busy_reg;
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !pop;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = gen_byte;
            out_last_next  = gen_last;
            out_done_next  = gen_done;
            busy_next      = !gen_last;
            cmd_next       = cur;
            step_next      = cur_step + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign empty      = !out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = out_last_reg;
    assign frame_done = out_done_reg;

`ifndef SYNTHESIS
    a_data_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cmd_reg.kind != CMD_DATA)
        else $error("a payload command spans more than one byte");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg)
        else $error("a waiting result was dropped");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> out_last_reg)
        else $error("frame end marked on a byte that is not the last of its item");
`endif

endmodule
